@@ src/hsl_pkg.sv @@
package hsl_pkg;

    // Input ranges.
    localparam int unsigned HUE_MAX = 359;
    localparam int unsigned PCT_MAX = 100;

    // Hue geometry in whole degrees.
    localparam int unsigned HUE_THIRD = 120;
    localparam int unsigned HUE_TURN  = 360;
    localparam int unsigned HUE_SEG   = 60;
    localparam int unsigned HUE_FALL  = 180;
    localparam int unsigned HUE_LOW   = 240;

    // Lightness below this value uses the l * (1 + s) form of q.
    localparam int unsigned LIGHT_HALF = 50;

    // Field widths.
    localparam int unsigned HUE_W  = 9;
    localparam int unsigned PCT_W  = 7;
    localparam int unsigned CHAN_W = 8;

    // Internal widths: p and q over 10000, channel numerator over 600000,
    // scaled numerator 255 * n + 300000 and the rounding quotient.
    localparam int unsigned PQ_W   = 14;
    localparam int unsigned FRAC_W = 6;
    localparam int unsigned NUM_W  = 20;
    localparam int unsigned X_W    = 28;
    localparam int unsigned QE_W   = 9;

    // Divide by 600000 through a reciprocal: 2^38 / 600000, rounded down.
    localparam int unsigned RECIP_SHIFT = 38;
    localparam int unsigned RECIP_W     = 19;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(458129);
    localparam logic [NUM_W-1:0]   DENOM = NUM_W'(600000);
    localparam logic [NUM_W-1:0]   HALF  = NUM_W'(300000);
    localparam int unsigned PROD_W = X_W + RECIP_W;
    localparam int unsigned REM_W  = X_W + 1;

    // Pipeline depth.
    localparam int unsigned NUM_STAGES = 6;

    typedef logic [NUM_STAGES-1:0] t_stage_en;

endpackage

@@ src/hsl_to_rgb_converter.sv @@
// HSL to RGB colour converter, six-stage pipeline.
// Throughput: one item per cycle while the output is not stalled; a stall holds only the stages that carry items.
// The reciprocal multiplier and its remainder check set the stage depth.
// Reset (synchronous, active low) clears all valid bits; the data path is not reset.
module hsl_to_rgb_converter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [hsl_pkg::HUE_W-1:0]     i_hue_deg,
    input  logic [hsl_pkg::PCT_W-1:0]     i_sat_pct,
    input  logic [hsl_pkg::PCT_W-1:0]     i_light_pct,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [hsl_pkg::CHAN_W-1:0]    o_red,
    output logic [hsl_pkg::CHAN_W-1:0]    o_green,
    output logic [hsl_pkg::CHAN_W-1:0]    o_blue,
    output logic                          o_range_error
);

    hsl_pkg::t_stage_en            r_valid;
    hsl_pkg::t_stage_en            n_valid;
    hsl_pkg::t_stage_en            w_en;
    logic [hsl_pkg::NUM_STAGES-1:1] r_err;
    logic                          w_err1;
    logic [hsl_pkg::PQ_W-1:0]      w_p;
    logic [hsl_pkg::PQ_W-1:0]      w_q;
    logic [hsl_pkg::HUE_W-1:0]     w_t_red;
    logic [hsl_pkg::HUE_W-1:0]     w_t_green;
    logic [hsl_pkg::HUE_W-1:0]     w_t_blue;
    logic [hsl_pkg::CHAN_W-1:0]    w_red;
    logic [hsl_pkg::CHAN_W-1:0]    w_green;
    logic [hsl_pkg::CHAN_W-1:0]    w_blue;

    // A stage loads when it is empty or the stage after it moves on, so
    // bubbles are squeezed out during a stall.
    always_comb begin
        w_en[hsl_pkg::NUM_STAGES-1] = !r_valid[hsl_pkg::NUM_STAGES-1] || !i_stall;
        for (int k = hsl_pkg::NUM_STAGES - 2; k >= 0; k--) begin
            w_en[k] = !r_valid[k] || w_en[k+1];
        end
    end

    always_comb begin
        n_valid[0] = w_en[0] ? i_valid : r_valid[0];
        for (int k = 1; k < hsl_pkg::NUM_STAGES; k++) begin
            n_valid[k] = w_en[k] ? r_valid[k-1] : r_valid[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // The range flag travels alongside the channel stages.
    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_err[1] <= w_err1;
        end
        for (int k = 2; k < hsl_pkg::NUM_STAGES; k++) begin
            if (w_en[k]) begin
                r_err[k] <= r_err[k-1];
            end
        end
    end

    hsl_prep u_prep (
        .i_clk         (i_clk),
        .i_en          (w_en[0]),
        .i_hue_deg     (i_hue_deg),
        .i_sat_pct     (i_sat_pct),
        .i_light_pct   (i_light_pct),
        .o_p           (w_p),
        .o_q           (w_q),
        .o_t_red       (w_t_red),
        .o_t_green     (w_t_green),
        .o_t_blue      (w_t_blue),
        .o_range_error (w_err1)
    );

    hsl_chan u_chan_red (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_p    (w_p),
        .i_q    (w_q),
        .i_t    (w_t_red),
        .o_chan (w_red)
    );

    hsl_chan u_chan_green (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_p    (w_p),
        .i_q    (w_q),
        .i_t    (w_t_green),
        .o_chan (w_green)
    );

    hsl_chan u_chan_blue (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_p    (w_p),
        .i_q    (w_q),
        .i_t    (w_t_blue),
        .o_chan (w_blue)
    );

    // Out-of-range items show zero channels.
    assign o_stall       = !w_en[0];
    assign o_valid       = r_valid[hsl_pkg::NUM_STAGES-1];
    assign o_range_error = r_err[hsl_pkg::NUM_STAGES-1];
    assign o_red         = o_range_error ? '0 : w_red;
    assign o_green       = o_range_error ? '0 : w_green;
    assign o_blue        = o_range_error ? '0 : w_blue;

endmodule

@@ src/hsl_prep.sv @@
module hsl_prep (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [hsl_pkg::HUE_W-1:0]     i_hue_deg,
    input  logic [hsl_pkg::PCT_W-1:0]     i_sat_pct,
    input  logic [hsl_pkg::PCT_W-1:0]     i_light_pct,
    output logic [hsl_pkg::PQ_W-1:0]      o_p,
    output logic [hsl_pkg::PQ_W-1:0]      o_q,
    output logic [hsl_pkg::HUE_W-1:0]     o_t_red,
    output logic [hsl_pkg::HUE_W-1:0]     o_t_green,
    output logic [hsl_pkg::HUE_W-1:0]     o_t_blue,
    output logic                          o_range_error
);

    logic [15:0]                  n_ls;
    logic [15:0]                  n_hund_l;
    logic [15:0]                  n_hund_s;
    logic [15:0]                  n_q_wide;
    logic [15:0]                  n_p_wide;
    logic [hsl_pkg::HUE_W:0]      n_sum_red;
    logic [hsl_pkg::HUE_W-1:0]    n_t_red;
    logic [hsl_pkg::HUE_W-1:0]    n_t_blue;
    logic                         n_err;
    logic [hsl_pkg::PQ_W-1:0]     r_p;
    logic [hsl_pkg::PQ_W-1:0]     r_q;
    logic [hsl_pkg::HUE_W-1:0]    r_t_red;
    logic [hsl_pkg::HUE_W-1:0]    r_t_green;
    logic [hsl_pkg::HUE_W-1:0]    r_t_blue;
    logic                         r_err;

    // Range check; out-of-range items are zeroed at the output.
    assign n_err = (i_hue_deg > hsl_pkg::HUE_W'(hsl_pkg::HUE_MAX))
                || (i_sat_pct > hsl_pkg::PCT_W'(hsl_pkg::PCT_MAX))
                || (i_light_pct > hsl_pkg::PCT_W'(hsl_pkg::PCT_MAX));

    // q and p as numerators over 10000. With zero saturation both equal
    // 100 * l, which makes every channel the rounded lightness.
    always_comb begin
        n_ls     = 16'(i_light_pct) * 16'(i_sat_pct);
        n_hund_l = 16'(i_light_pct) * 16'(hsl_pkg::PCT_MAX);
        n_hund_s = 16'(i_sat_pct) * 16'(hsl_pkg::PCT_MAX);
        if (i_light_pct < hsl_pkg::PCT_W'(hsl_pkg::LIGHT_HALF)) begin
            n_q_wide = n_hund_l + n_ls;
        end else begin
            n_q_wide = n_hund_l + n_hund_s - n_ls;
        end
        n_p_wide = (n_hund_l << 1) - n_q_wide;
    end

    // Hue positions of the three channels, wrapped into one turn. A position
    // of exactly one full turn is kept and falls into the low segment.
    always_comb begin
        n_sum_red = (hsl_pkg::HUE_W+1)'(i_hue_deg) + (hsl_pkg::HUE_W+1)'(hsl_pkg::HUE_THIRD);
        if (n_sum_red > (hsl_pkg::HUE_W+1)'(hsl_pkg::HUE_TURN)) begin
            n_t_red = hsl_pkg::HUE_W'(n_sum_red - (hsl_pkg::HUE_W+1)'(hsl_pkg::HUE_TURN));
        end else begin
            n_t_red = hsl_pkg::HUE_W'(n_sum_red);
        end
        if (i_hue_deg >= hsl_pkg::HUE_W'(hsl_pkg::HUE_THIRD)) begin
            n_t_blue = i_hue_deg - hsl_pkg::HUE_W'(hsl_pkg::HUE_THIRD);
        end else begin
            n_t_blue = i_hue_deg + hsl_pkg::HUE_W'(hsl_pkg::HUE_LOW);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p       <= hsl_pkg::PQ_W'(n_p_wide);
            r_q       <= hsl_pkg::PQ_W'(n_q_wide);
            r_t_red   <= n_t_red;
            r_t_green <= i_hue_deg;
            r_t_blue  <= n_t_blue;
            r_err     <= n_err;
        end
    end

    assign o_p           = r_p;
    assign o_q           = r_q;
    assign o_t_red       = r_t_red;
    assign o_t_green     = r_t_green;
    assign o_t_blue      = r_t_blue;
    assign o_range_error = r_err;

endmodule

@@ src/hsl_chan.sv @@
module hsl_chan (
    input  logic                          i_clk,
    input  hsl_pkg::t_stage_en            i_en,
    input  logic [hsl_pkg::PQ_W-1:0]      i_p,
    input  logic [hsl_pkg::PQ_W-1:0]      i_q,
    input  logic [hsl_pkg::HUE_W-1:0]     i_t,
    output logic [hsl_pkg::CHAN_W-1:0]    o_chan
);

    logic [hsl_pkg::FRAC_W-1:0]   n_f;
    logic [hsl_pkg::HUE_W-1:0]    n_fall;
    logic [hsl_pkg::FRAC_W-1:0]   r_f;
    logic [hsl_pkg::NUM_W-1:0]    r_p60;
    logic [hsl_pkg::PQ_W-1:0]     r_d;
    logic [hsl_pkg::NUM_W-1:0]    r_num;
    logic [hsl_pkg::X_W-1:0]      r_x4;
    logic [hsl_pkg::X_W-1:0]      r_x5;
    logic [hsl_pkg::QE_W-1:0]     r_qe;
    logic [hsl_pkg::CHAN_W-1:0]   r_chan;
    logic [hsl_pkg::PROD_W-1:0]   w_prod;
    logic [hsl_pkg::REM_W-1:0]    w_back;
    logic [hsl_pkg::REM_W-1:0]    w_rem;
    logic [hsl_pkg::QE_W-1:0]     w_qe_fix;

    // Stage two: the channel is p + (q - p) * f / 60, with f picked by
    // the hue segment: rising, top, falling or bottom.
    always_comb begin
        n_fall = hsl_pkg::HUE_W'(hsl_pkg::HUE_LOW) - i_t;
        if (i_t < hsl_pkg::HUE_W'(hsl_pkg::HUE_SEG)) begin
            n_f = hsl_pkg::FRAC_W'(i_t);
        end else if (i_t < hsl_pkg::HUE_W'(hsl_pkg::HUE_FALL)) begin
            n_f = hsl_pkg::FRAC_W'(hsl_pkg::HUE_SEG);
        end else if (i_t < hsl_pkg::HUE_W'(hsl_pkg::HUE_LOW)) begin
            n_f = hsl_pkg::FRAC_W'(n_fall);
        end else begin
            n_f = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_f   <= n_f;
            r_p60 <= hsl_pkg::NUM_W'(i_p) * hsl_pkg::NUM_W'(hsl_pkg::HUE_SEG);
            r_d   <= i_q - i_p;
        end
    end

    // Stage three: channel numerator over 600000.
    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_num <= r_p60 + hsl_pkg::NUM_W'(r_d) * hsl_pkg::NUM_W'(r_f);
        end
    end

    // Stage four: scale by 255 and add half the denominator.
    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_x4 <= (hsl_pkg::X_W'(r_num) << 8) - hsl_pkg::X_W'(r_num)
                  + hsl_pkg::X_W'(hsl_pkg::HALF);
        end
    end

    // Stage five: reciprocal estimate of the quotient, at most one short.
    assign w_prod = hsl_pkg::PROD_W'(r_x4) * hsl_pkg::PROD_W'(hsl_pkg::RECIP);

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r_qe <= w_prod[hsl_pkg::RECIP_SHIFT +: hsl_pkg::QE_W];
            r_x5 <= r_x4;
        end
    end

    // Stage six: remainder check and a single correction step.
    assign w_back   = hsl_pkg::REM_W'(r_qe) * hsl_pkg::REM_W'(hsl_pkg::DENOM);
    assign w_rem    = hsl_pkg::REM_W'(r_x5) - w_back;
    assign w_qe_fix = (w_rem >= hsl_pkg::REM_W'(hsl_pkg::DENOM))
                    ? r_qe + hsl_pkg::QE_W'(1) : r_qe;

    always_ff @(posedge i_clk) begin
        if (i_en[5]) begin
            r_chan <= hsl_pkg::CHAN_W'(w_qe_fix);
        end
    end

    assign o_chan = r_chan;

endmodule

@@ src/hsl_checker.sv @@
module hsl_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          o_stall,
    input  logic                          o_valid,
    input  logic                          i_stall,
    input  logic [hsl_pkg::CHAN_W-1:0]    o_red,
    input  logic [hsl_pkg::CHAN_W-1:0]    o_green,
    input  logic [hsl_pkg::CHAN_W-1:0]    o_blue,
    input  logic                          o_range_error
);

    // A stalled result stays valid.
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result item dropped while stalled");

    // A stalled result keeps its channels.
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_red) && $stable(o_green) && $stable(o_blue)
            && $stable(o_range_error))
        else $error("result item changed while stalled");

    // An out-of-range item carries zero channels.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_range_error |-> o_red == '0 && o_green == '0 && o_blue == '0)
        else $error("range error with non-zero channels");

    // With the output stage empty, the pipeline can always take an item.
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled while output stage empty");

    // Reset leaves no result behind.
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !o_valid)
        else $error("result item present straight after reset");

endmodule

bind hsl_to_rgb_converter hsl_checker u_hsl_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_red         (o_red),
    .o_green       (o_green),
    .o_blue        (o_blue),
    .o_range_error (o_range_error)
);
